### sv/ftce_pkg.sv
// ----------------------------------------------------------------------------
// ftce_pkg: shared types and the step program of the cart-table Euler block
// Holds the sign-magnitude operand type, the operand slot codes, the result
// field codes and the micro-op table that the sequencer walks for each tick.
// ----------------------------------------------------------------------------
package ftce_pkg;

  // Sign and 64-bit magnitude operand
  typedef struct packed {
    logic        neg;
    logic [63:0] mag;
  } fx_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_MUL,
    OP_DIV
  } op_kind_e;

  // Operand slots: codes below 16 are named registers, 16 and up are scratch
  typedef enum logic [4:0] {
    SL_U    = 5'd0,
    SL_DT   = 5'd1,
    SL_M    = 5'd2,
    SL_H    = 5'd3,
    SL_K    = 5'd4,
    SL_C    = 5'd5,
    SL_IY   = 5'd6,
    SL_G    = 5'd7,
    SL_P    = 5'd8,
    SL_TH   = 5'd9,
    SL_V    = 5'd10,
    SL_W    = 5'd11,
    SL_ZERO = 5'd12,
    SL_DEN  = 5'd16,
    SL_MG   = 5'd17,
    SL_A30  = 5'd18,
    SL_A31  = 5'd19,
    SL_A33  = 5'd20,
    SL_B3   = 5'd21,
    SL_T    = 5'd22,
    SL_T2   = 5'd23,
    SL_DX3  = 5'd24,
    SL_MY   = 5'd25
  } slot_e;

  // Result word codes, in the order of the output word
  typedef enum logic [3:0] {
    OUT_N0   = 4'd0,
    OUT_N1   = 4'd1,
    OUT_N2   = 4'd2,
    OUT_N3   = 4'd3,
    OUT_RC   = 4'd4,
    OUT_FCA  = 4'd5,
    OUT_ZMP  = 4'd6,
    OUT_MY   = 4'd7,
    OUT_OLD  = 4'd8,
    OUT_NONE = 4'd15
  } out_e;

  typedef enum logic [2:0] {
    CFG_MASS    = 3'd0,
    CFG_HEIGHT  = 3'd1,
    CFG_STIFF   = 3'd2,
    CFG_DAMP    = 3'd3,
    CFG_INERTIA = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_WRITE,
    ST_FINISH
  } seq_state_e;

  typedef struct packed {
    op_kind_e kind;
    slot_e    sa;
    slot_e    sb;
    logic     negb;
    logic     negr;
    slot_e    dst;
    out_e     oidx;
  } uop_t;

  localparam int unsigned PC_W     = 6;
  localparam logic [PC_W-1:0] PC_LAST = 6'd32;
  localparam int unsigned SCR_W    = 4;
  localparam int unsigned OUT_WORDS = 9;

  function automatic uop_t mk_uop(input op_kind_e kind, input slot_e sa, input slot_e sb,
                                  input logic negb, input logic negr, input slot_e dst,
                                  input out_e oidx);
    uop_t u;
    u.kind = kind;
    u.sa   = sa;
    u.sb   = sb;
    u.negb = negb;
    u.negr = negr;
    u.dst  = dst;
    u.oidx = oidx;
    return u;
  endfunction

  // Step program: coefficients, acceleration, state update, derived words
  function automatic uop_t prog_rom(input logic [PC_W-1:0] pc);
    uop_t u;
    u = mk_uop(OP_ADD, SL_ZERO, SL_ZERO, 1'b0, 1'b0, SL_ZERO, OUT_NONE);
    case (pc)
      6'd0:  u = mk_uop(OP_MUL, SL_M,   SL_H,    1'b0, 1'b0, SL_T,    OUT_NONE);
      6'd1:  u = mk_uop(OP_MUL, SL_T,   SL_H,    1'b0, 1'b0, SL_T2,   OUT_NONE);
      6'd2:  u = mk_uop(OP_ADD, SL_T2,  SL_IY,   1'b0, 1'b0, SL_DEN,  OUT_NONE);
      6'd3:  u = mk_uop(OP_MUL, SL_M,   SL_G,    1'b0, 1'b0, SL_MG,   OUT_NONE);
      6'd4:  u = mk_uop(OP_DIV, SL_MG,  SL_DEN,  1'b0, 1'b1, SL_A30,  OUT_NONE);
      6'd5:  u = mk_uop(OP_MUL, SL_MG,  SL_H,    1'b0, 1'b0, SL_T2,   OUT_NONE);
      6'd6:  u = mk_uop(OP_ADD, SL_T2,  SL_K,    1'b1, 1'b0, SL_T2,   OUT_NONE);
      6'd7:  u = mk_uop(OP_DIV, SL_T2,  SL_DEN,  1'b0, 1'b0, SL_A31,  OUT_NONE);
      6'd8:  u = mk_uop(OP_DIV, SL_C,   SL_DEN,  1'b0, 1'b1, SL_A33,  OUT_NONE);
      6'd9:  u = mk_uop(OP_DIV, SL_T,   SL_DEN,  1'b0, 1'b0, SL_B3,   OUT_NONE);
      6'd10: u = mk_uop(OP_MUL, SL_A30, SL_P,    1'b0, 1'b0, SL_T,    OUT_NONE);
      6'd11: u = mk_uop(OP_MUL, SL_A31, SL_TH,   1'b0, 1'b0, SL_T2,   OUT_NONE);
      6'd12: u = mk_uop(OP_ADD, SL_T,   SL_T2,   1'b0, 1'b0, SL_A30,  OUT_NONE);
      6'd13: u = mk_uop(OP_MUL, SL_A33, SL_W,    1'b0, 1'b0, SL_T,    OUT_NONE);
      6'd14: u = mk_uop(OP_MUL, SL_B3,  SL_U,    1'b0, 1'b0, SL_T2,   OUT_NONE);
      6'd15: u = mk_uop(OP_ADD, SL_T,   SL_T2,   1'b0, 1'b0, SL_T,    OUT_NONE);
      6'd16: u = mk_uop(OP_ADD, SL_A30, SL_T,    1'b0, 1'b0, SL_A30,  OUT_NONE);
      6'd17: u = mk_uop(OP_MUL, SL_A30, SL_DT,   1'b0, 1'b0, SL_DX3,  OUT_NONE);
      6'd18: u = mk_uop(OP_ADD, SL_P,   SL_ZERO, 1'b0, 1'b0, SL_ZERO, OUT_OLD);
      6'd19: u = mk_uop(OP_MUL, SL_V,   SL_DT,   1'b0, 1'b0, SL_T,    OUT_NONE);
      6'd20: u = mk_uop(OP_ADD, SL_P,   SL_T,    1'b0, 1'b0, SL_P,    OUT_N0);
      6'd21: u = mk_uop(OP_MUL, SL_W,   SL_DT,   1'b0, 1'b0, SL_T,    OUT_NONE);
      6'd22: u = mk_uop(OP_ADD, SL_TH,  SL_T,    1'b0, 1'b0, SL_TH,   OUT_N1);
      6'd23: u = mk_uop(OP_MUL, SL_U,   SL_DT,   1'b0, 1'b0, SL_T,    OUT_NONE);
      6'd24: u = mk_uop(OP_ADD, SL_V,   SL_T,    1'b0, 1'b0, SL_V,    OUT_N2);
      6'd25: u = mk_uop(OP_ADD, SL_W,   SL_DX3,  1'b0, 1'b0, SL_W,    OUT_N3);
      6'd26: u = mk_uop(OP_MUL, SL_K,   SL_TH,   1'b0, 1'b0, SL_T,    OUT_NONE);
      6'd27: u = mk_uop(OP_MUL, SL_C,   SL_W,    1'b0, 1'b0, SL_T2,   OUT_NONE);
      6'd28: u = mk_uop(OP_ADD, SL_T,   SL_T2,   1'b0, 1'b0, SL_MY,   OUT_MY);
      6'd29: u = mk_uop(OP_DIV, SL_MY,  SL_MG,   1'b0, 1'b1, SL_ZERO, OUT_ZMP);
      6'd30: u = mk_uop(OP_MUL, SL_TH,  SL_H,    1'b0, 1'b0, SL_T,    OUT_NONE);
      6'd31: u = mk_uop(OP_ADD, SL_P,   SL_T,    1'b1, 1'b0, SL_ZERO, OUT_RC);
      6'd32: u = mk_uop(OP_MUL, SL_DX3, SL_H,    1'b0, 1'b0, SL_ZERO, OUT_FCA);
      default: u = mk_uop(OP_ADD, SL_ZERO, SL_ZERO, 1'b0, 1'b0, SL_ZERO, OUT_NONE);
    endcase
    return u;
  endfunction

  // Clear the sign of a zero magnitude
  function automatic fx_t fx_norm(input fx_t a);
    fx_t r;
    r.mag = a.mag;
    r.neg = a.neg && (a.mag != 64'd0);
    return r;
  endfunction

  // Saturating sign-magnitude add
  function automatic fx_t fx_add(input fx_t a, input fx_t b);
    fx_t         r;
    logic [64:0] s;
    s = {1'b0, a.mag} + {1'b0, b.mag};
    if (a.neg == b.neg) begin
      r.neg = a.neg;
      r.mag = s[64] ? {64{1'b1}} : s[63:0];
    end else if (a.mag >= b.mag) begin
      r.neg = a.neg;
      r.mag = a.mag - b.mag;
    end else begin
      r.neg = b.neg;
      r.mag = b.mag - a.mag;
    end
    return fx_norm(r);
  endfunction

endpackage

### sv/flexible_table_cart_euler_step.sv
// ----------------------------------------------------------------------------
// flexible_table_cart_euler_step: one forward-Euler tick of a cart-table model
// A small sequencer runs a 33-step program over one shared add, a 32x32
// partial-product multiplier and a one-bit-per-cycle divider.
// ----------------------------------------------------------------------------
// A new request is accepted only in the idle state, once the previous result
// has been loaded into the output register; each of the five quotients comes
// from the radix-2 divider, each product from the partial-product multiplier.
// Reset clears the model state to zero and loads the register defaults
// (mass 58, height 0.8, stiffness 100, damping 0.1, inertia 0).
module flexible_table_cart_euler_step #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [2:0]                             cfg_idx_i,
  input  logic [WORD_BITS-1:0]                   cfg_data_i,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // cart_accel, step_time
  input  logic [((2*WORD_BITS+7)/8)*8-1:0]       s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // next_position, next_angle, next_velocity, next_angle_rate, real_com,
  // flex_com_accel, zmp_position, ankle_moment, old_position
  output logic [((9*WORD_BITS+7)/8)*8-1:0]       m_axis_tdata,
  // bad_setup
  output logic [0:0]                             m_axis_tuser
);

  localparam logic [63:0] WMASK    = {64{1'b1}} >> (64 - WORD_BITS);
  localparam logic [63:0] WMAXMAG  = WMASK >> 1;
  localparam logic [63:0] WMINMAG  = WMAXMAG + 64'd1;
  localparam logic [63:0] GRAV     = ((64'd98 << FRAC_BITS) + 64'd5) / 64'd10;
  localparam logic [63:0] MASS_RST = (64'd58 << FRAC_BITS) & WMASK;
  localparam logic [63:0] HGT_RST  = (((64'd8 << FRAC_BITS) + 64'd5) / 64'd10) & WMASK;
  localparam logic [63:0] STF_RST  = (64'd100 << FRAC_BITS) & WMASK;
  localparam logic [63:0] DMP_RST  = (((64'd1 << FRAC_BITS) + 64'd5) / 64'd10) & WMASK;

  // Saturate to the signed word and encode as two's complement
  function automatic logic [WORD_BITS-1:0] enc(input ftce_pkg::fx_t a);
    logic [63:0] m;
    m = a.mag;
    if (a.neg) begin
      if (m > WMINMAG) m = WMINMAG;
      m = 64'd0 - m;
    end else if (m > WMAXMAG) begin
      m = WMAXMAG;
    end
    return m[WORD_BITS-1:0];
  endfunction

  function automatic ftce_pkg::fx_t dec_s(input logic [WORD_BITS-1:0] v);
    ftce_pkg::fx_t r;
    logic [63:0]   e;
    e = 64'(v);
    if (v[WORD_BITS-1]) begin
      r.neg = 1'b1;
      r.mag = ((~e) & WMASK) + 64'd1;
    end else begin
      r.neg = 1'b0;
      r.mag = e;
    end
    return r;
  endfunction

  function automatic ftce_pkg::fx_t dec_u(input logic [WORD_BITS-1:0] v);
    ftce_pkg::fx_t r;
    r.neg = 1'b0;
    r.mag = 64'(v);
    return r;
  endfunction

  ftce_pkg::seq_state_e           state_q, state_d;
  logic [ftce_pkg::PC_W-1:0]      pc_q;
  logic [7:0]                     cnt_q;
  ftce_pkg::uop_t                 uop;

  logic [WORD_BITS-1:0] mass_q, height_q, stiff_q, damp_q, inertia_q;
  logic [WORD_BITS-1:0] pos_q, ang_q, vel_q, rate_q;
  logic [WORD_BITS-1:0] accel_q, dt_q;

  ftce_pkg::fx_t scr_mem [2**ftce_pkg::SCR_W];
  ftce_pkg::fx_t named_v [16];
  ftce_pkg::fx_t op_a_q, op_b_q, b_eff;
  ftce_pkg::fx_t res_raw, res;

  logic [63:0]  pp_q, pp_d;
  logic [1:0]   pp_sel_q;
  logic [31:0]  pa, pb;
  logic [127:0] acc_q, acc_d, pp_ext, mul_sh;
  logic [63:0]  rem_q, rem_d, quo_q, quo_d;
  logic         ovf_q, ovf_d;
  logic [64:0]  rem_ext;
  logic         take;

  logic [WORD_BITS-1:0] stage_q [ftce_pkg::OUT_WORDS];
  logic [WORD_BITS-1:0] out_q   [ftce_pkg::OUT_WORDS];
  logic                 bad_stage_q, bad_out_q;
  logic                 m_valid_q;
  logic                 load_out, wr_en, in_acc;

  assign uop    = ftce_pkg::prog_rom(pc_q);
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ftce_pkg::ST_IDLE: begin
        if (s_axis_tvalid) state_d = ftce_pkg::ST_FETCH;
      end
      ftce_pkg::ST_FETCH: begin
        state_d = (uop.kind == ftce_pkg::OP_ADD) ? ftce_pkg::ST_WRITE : ftce_pkg::ST_EXEC;
      end
      ftce_pkg::ST_EXEC: begin
        if ((uop.kind == ftce_pkg::OP_MUL && cnt_q == 8'd4) ||
            (uop.kind == ftce_pkg::OP_DIV && cnt_q == 8'd128)) begin
          state_d = ftce_pkg::ST_WRITE;
        end
      end
      ftce_pkg::ST_WRITE: begin
        state_d = (pc_q == ftce_pkg::PC_LAST) ? ftce_pkg::ST_FINISH : ftce_pkg::ST_FETCH;
      end
      ftce_pkg::ST_FINISH: begin
        if (!m_valid_q || m_axis_tready) state_d = ftce_pkg::ST_IDLE;
      end
      default: state_d = ftce_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    wr_en         = 1'b0;
    load_out      = 1'b0;
    unique case (state_q)
      ftce_pkg::ST_IDLE:   s_axis_tready = 1'b1;
      ftce_pkg::ST_WRITE:  wr_en = 1'b1;
      ftce_pkg::ST_FINISH: load_out = !m_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  // Hold sequencer state, program counter and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ftce_pkg::ST_IDLE;
      pc_q      <= '0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ftce_pkg::ST_IDLE) pc_q <= '0;
      else if (wr_en) pc_q <= pc_q + 1'b1;
      if (state_q == ftce_pkg::ST_EXEC) cnt_q <= cnt_q + 1'b1;
      else cnt_q <= '0;
      if (load_out) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
    end
  end

  // Configuration registers and model state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q    <= MASS_RST[WORD_BITS-1:0];
      height_q  <= HGT_RST[WORD_BITS-1:0];
      stiff_q   <= STF_RST[WORD_BITS-1:0];
      damp_q    <= DMP_RST[WORD_BITS-1:0];
      inertia_q <= '0;
      pos_q     <= '0;
      ang_q     <= '0;
      vel_q     <= '0;
      rate_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ftce_pkg::CFG_MASS:    mass_q    <= cfg_data_i;
          ftce_pkg::CFG_HEIGHT:  height_q  <= cfg_data_i;
          ftce_pkg::CFG_STIFF:   stiff_q   <= cfg_data_i;
          ftce_pkg::CFG_DAMP:    damp_q    <= cfg_data_i;
          ftce_pkg::CFG_INERTIA: inertia_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (wr_en) begin
        case (uop.dst)
          ftce_pkg::SL_P:  pos_q  <= enc(res);
          ftce_pkg::SL_TH: ang_q  <= enc(res);
          ftce_pkg::SL_V:  vel_q  <= enc(res);
          ftce_pkg::SL_W:  rate_q <= enc(res);
          default: ;
        endcase
      end
    end
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      accel_q <= s_axis_tdata[WORD_BITS-1:0];
      dt_q    <= s_axis_tdata[2*WORD_BITS-1:WORD_BITS];
    end
  end

  // Named operand sources
  always_comb begin
    for (int i = 0; i < 16; i++) named_v[i] = '0;
    named_v[4'(ftce_pkg::SL_U)]  = dec_s(accel_q);
    named_v[4'(ftce_pkg::SL_DT)] = dec_u(dt_q);
    named_v[4'(ftce_pkg::SL_M)]  = dec_u(mass_q);
    named_v[4'(ftce_pkg::SL_H)]  = dec_u(height_q);
    named_v[4'(ftce_pkg::SL_K)]  = dec_u(stiff_q);
    named_v[4'(ftce_pkg::SL_C)]  = dec_u(damp_q);
    named_v[4'(ftce_pkg::SL_IY)] = dec_u(inertia_q);
    named_v[4'(ftce_pkg::SL_G)]  = '{neg: 1'b0, mag: GRAV};
    named_v[4'(ftce_pkg::SL_P)]  = dec_s(pos_q);
    named_v[4'(ftce_pkg::SL_TH)] = dec_s(ang_q);
    named_v[4'(ftce_pkg::SL_V)]  = dec_s(vel_q);
    named_v[4'(ftce_pkg::SL_W)]  = dec_s(rate_q);
  end

  // Fetch operands; write scratch results
  always_ff @(posedge clk_i) begin
    if (state_q == ftce_pkg::ST_FETCH) begin
      op_a_q <= uop.sa[4] ? scr_mem[uop.sa[3:0]] : named_v[uop.sa[3:0]];
      op_b_q <= uop.sb[4] ? scr_mem[uop.sb[3:0]] : named_v[uop.sb[3:0]];
    end
    if (wr_en && uop.dst[4]) scr_mem[uop.dst[3:0]] <= res;
  end

  assign b_eff = '{neg: op_b_q.neg ^ uop.negb, mag: op_b_q.mag};

  // Multiplier partial products
  always_comb begin
    case (cnt_q[1:0])
      2'd0: begin pa = op_a_q.mag[31:0];  pb = op_b_q.mag[31:0];  end
      2'd1: begin pa = op_a_q.mag[31:0];  pb = op_b_q.mag[63:32]; end
      2'd2: begin pa = op_a_q.mag[63:32]; pb = op_b_q.mag[31:0];  end
      default: begin pa = op_a_q.mag[63:32]; pb = op_b_q.mag[63:32]; end
    endcase
    pp_d = 64'(pa) * 64'(pb);
    case (pp_sel_q)
      2'd0:    pp_ext = {64'd0, pp_q};
      2'd3:    pp_ext = {pp_q, 64'd0};
      default: pp_ext = {32'd0, pp_q, 32'd0};
    endcase
  end

  // Divider bit step: shift in the top dividend bit, subtract when it fits
  always_comb begin
    rem_ext = {rem_q, acc_q[127]};
    take    = rem_ext >= {1'b0, op_b_q.mag};
    rem_d   = take ? 64'(rem_ext - {1'b0, op_b_q.mag}) : rem_ext[63:0];
    quo_d   = {quo_q[62:0], take};
    ovf_d   = ovf_q | quo_q[63];
    acc_d   = acc_q;
    if (state_q == ftce_pkg::ST_EXEC) begin
      if (uop.kind == ftce_pkg::OP_MUL) begin
        if (cnt_q != 8'd0) acc_d = acc_q + pp_ext;
      end else if (cnt_q == 8'd0) begin
        acc_d = {64'd0, op_a_q.mag} << FRAC_BITS;
      end else begin
        acc_d = {acc_q[126:0], 1'b0};
      end
    end else if (state_q == ftce_pkg::ST_FETCH) begin
      acc_d = '0;
    end
  end

  // Advance the shared unit
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (state_q == ftce_pkg::ST_EXEC) begin
      if (uop.kind == ftce_pkg::OP_MUL) begin
        if (cnt_q[7:2] == 6'd0) begin
          pp_q     <= pp_d;
          pp_sel_q <= cnt_q[1:0];
        end
      end else if (cnt_q == 8'd0) begin
        rem_q <= '0;
        quo_q <= '0;
        ovf_q <= 1'b0;
      end else begin
        rem_q <= rem_d;
        quo_q <= quo_d;
        ovf_q <= ovf_d;
      end
    end
  end

  // Form the step result
  always_comb begin
    mul_sh  = acc_q >> FRAC_BITS;
    res_raw = '0;
    case (uop.kind)
      ftce_pkg::OP_ADD: res_raw = ftce_pkg::fx_add(op_a_q, b_eff);
      ftce_pkg::OP_MUL: begin
        res_raw.neg = op_a_q.neg ^ b_eff.neg;
        res_raw.mag = (mul_sh[127:64] != 64'd0) ? {64{1'b1}} : mul_sh[63:0];
      end
      ftce_pkg::OP_DIV: begin
        if (op_b_q.mag != 64'd0) begin
          res_raw.neg = op_a_q.neg ^ b_eff.neg;
          res_raw.mag = ovf_q ? {64{1'b1}} : quo_q;
        end
      end
      default: res_raw = '0;
    endcase
    res = ftce_pkg::fx_norm('{neg: res_raw.neg ^ uop.negr, mag: res_raw.mag});
  end

  // Stage result words, then hand them to the output register
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      if (uop.oidx != ftce_pkg::OUT_NONE) stage_q[uop.oidx] <= enc(res);
      if (uop.dst == ftce_pkg::SL_DEN) bad_stage_q <= (res.mag == 64'd0);
    end
    if (load_out) begin
      out_q     <= stage_q;
      bad_out_q <= bad_stage_q;
    end
  end

  // Pack the result
  always_comb begin
    m_axis_tdata = '0;
    for (int i = 0; i < ftce_pkg::OUT_WORDS; i++) begin
      m_axis_tdata[i*WORD_BITS +: WORD_BITS] = out_q[i];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = bad_out_q;

endmodule
